### src/bsp_pkg.sv
package bsp_pkg;

  // map and fixed-point formats
  localparam int MAP_BITS  = 10;
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = MAP_BITS + FRAC_BITS;
  localparam int REL_W     = POS_W + 2;
  localparam int VEC_W     = 16;
  localparam int VEC_FRAC  = 14;
  localparam int PROD_W    = REL_W + VEC_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int DET_W     = 2 * VEC_W + 1;

  // screen resolution registers
  localparam int RES_W     = 13;
  localparam int HALF_W    = RES_W - 1;
  localparam logic [RES_W-1:0] RES_MIN     = RES_W'(1);
  localparam logic [RES_W-1:0] RES_MAX     = RES_W'(4096);
  localparam logic [RES_W-1:0] RES_X_RESET = RES_W'(640);
  localparam logic [RES_W-1:0] RES_Y_RESET = RES_W'(480);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_Y = 1'b1;

  // result field widths
  localparam int DEPTH_W = 32;
  localparam int COL_OUT_W  = 16;
  localparam int SIZE_W  = 16;
  localparam int SX_W    = 15;
  localparam int EX_W    = 16;
  localparam int SY_W    = 13;
  localparam int EY_W    = 12;

  // column numerator: (res_x/2) * (tx + ty)
  localparam int SUM_W   = DEPTH_W + 1;
  localparam int COLN_W  = SUM_W + RES_W;

  // shared divider geometry
  localparam int DIV_UW_A = NUM_W + VEC_FRAC;
  localparam int DIV_UW_B = (COLN_W > RES_W + FRAC_BITS) ? COLN_W : RES_W + FRAC_BITS;
  localparam int DIV_UW   = (DIV_UW_A > DIV_UW_B) ? DIV_UW_A : DIV_UW_B;
  localparam int DIV_DW   = 32;
  localparam int DIV_QW   = 32;

  // centring offset of half a cell
  localparam logic [REL_W-1:0] HALF_CELL = REL_W'(1) << (FRAC_BITS - 1);

  // queue between front and back
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = 3;
  localparam int Q_CW    = Q_AW + 1;

  // saturation limits
  localparam logic [DIV_QW-1:0] CAP_POS = 32'h7FFF_FFFF;
  localparam logic [DIV_QW-1:0] CAP_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic signed [DET_W-1:0] det;
  } bsp_job_t;

  typedef struct packed {
    logic                fault;
    logic                neg_a;
    logic                neg_b;
    logic [DEPTH_W-1:0]  ty;
  } bsp_side_t;

  // clamp a resolution write into 1..4096
  function automatic logic [RES_W-1:0] clamp_res(input logic [RES_W-1:0] v);
    logic [RES_W-1:0] r;
    if (v < RES_MIN) begin
      r = RES_MIN;
    end else if (v > RES_MAX) begin
      r = RES_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // apply sign and 32-bit saturation to a quotient magnitude
  function automatic logic [DEPTH_W-1:0] sat_q(input logic [DIV_QW-1:0] q,
                                               input logic ov, input logic neg);
    logic [DIV_QW-1:0] cap;
    logic [DIV_QW-1:0] m;
    cap = neg ? CAP_NEG : CAP_POS;
    m   = (ov || (q > cap)) ? cap : q;
    return neg ? DEPTH_W'(DIV_QW'(0) - m) : DEPTH_W'(m);
  endfunction

endpackage

### src/bsp_front.sv
module bsp_front import bsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [MAP_BITS-1:0]      in_sprite_cell_x,
  input  logic [MAP_BITS-1:0]      in_sprite_cell_y,
  input  logic [POS_W-1:0]         in_player_x,
  input  logic [POS_W-1:0]         in_player_y,
  input  logic signed [VEC_W-1:0]  in_view_dir_x,
  input  logic signed [VEC_W-1:0]  in_view_dir_y,
  input  logic signed [VEC_W-1:0]  in_cam_plane_x,
  input  logic signed [VEC_W-1:0]  in_cam_plane_y,
  input  logic [Q_CW-1:0]          q_count,
  output logic                     push,
  output bsp_job_t                 job
);

  logic                     v1_r, v2_r;
  logic signed [REL_W-1:0]  rx_r, ry_r, rx_nxt, ry_nxt;
  logic signed [VEC_W-1:0]  dx_r, dy_r, px_r, py_r;
  logic signed [PROD_W-1:0] p_dyrx_r, p_dxry_r, p_pxry_r, p_pyrx_r;
  logic signed [2*VEC_W-1:0] p_pxdy_r, p_dxpy_r;
  logic [Q_CW:0]            occupancy;
  logic                     accept;

  // credit check: queue entries plus items still in the front stages
  assign occupancy = (Q_CW+1)'(q_count) + (Q_CW+1)'(v1_r) + (Q_CW+1)'(v2_r);
  assign in_stall  = occupancy >= (Q_CW+1)'(Q_DEPTH);
  assign accept    = in_valid && !in_stall;

  // sprite offset from the player, cell centred
  assign rx_nxt = $signed({2'b00, in_sprite_cell_x, {FRAC_BITS{1'b0}}} + HALF_CELL
                          - {2'b00, in_player_x});
  assign ry_nxt = $signed({2'b00, in_sprite_cell_y, {FRAC_BITS{1'b0}}} + HALF_CELL
                          - {2'b00, in_player_y});

  // valid bits of the two front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  // stage 1: input transfer and offsets
  always_ff @(posedge clk) begin
    if (accept) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      dx_r <= in_view_dir_x;
      dy_r <= in_view_dir_y;
      px_r <= in_cam_plane_x;
      py_r <= in_cam_plane_y;
    end
  end

  // stage 2: matrix products
  always_ff @(posedge clk) begin
    p_dyrx_r <= dy_r * rx_r;
    p_dxry_r <= dx_r * ry_r;
    p_pxry_r <= px_r * ry_r;
    p_pyrx_r <= py_r * rx_r;
    p_pxdy_r <= px_r * dy_r;
    p_dxpy_r <= dx_r * py_r;
  end

  // numerators and determinant go to the queue
  assign push      = v2_r;
  assign job.num_x = NUM_W'(p_dyrx_r) - NUM_W'(p_dxry_r);
  assign job.num_y = NUM_W'(p_pxry_r) - NUM_W'(p_pyrx_r);
  assign job.det   = DET_W'(p_pxdy_r) - DET_W'(p_dxpy_r);

endmodule

### src/bsp_queue.sv
module bsp_queue import bsp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bsp_job_t        job_in,
  input  logic            pop,
  output bsp_job_t        head,
  output logic            empty,
  output logic [Q_CW-1:0] count
);

  bsp_job_t        mem_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      count_r <= count_r + Q_CW'(push) - Q_CW'(pop);
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

### src/bsp_div2.sv
module bsp_div2 import bsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIV_UW-1:0] in_ua,
  input  logic [DIV_UW-1:0] in_ub,
  input  logic [DIV_DW-1:0] in_d,
  input  bsp_side_t         in_side,
  output logic              out_valid,
  output logic [DIV_QW-1:0] out_qa,
  output logic [DIV_QW-1:0] out_qb,
  output logic              out_ova,
  output logic              out_ovb,
  output bsp_side_t         out_side
);

  localparam int HI_W  = DIV_UW - DIV_QW;
  localparam int CMP_W = (HI_W > DIV_DW) ? HI_W : DIV_DW;

  logic              valid_r [0:DIV_QW];
  logic [DIV_DW-1:0] d_r     [0:DIV_QW];
  logic [DIV_DW-1:0] rem_a_r [0:DIV_QW];
  logic [DIV_DW-1:0] rem_b_r [0:DIV_QW];
  logic [DIV_QW-1:0] sh_a_r  [0:DIV_QW];
  logic [DIV_QW-1:0] sh_b_r  [0:DIV_QW];
  logic              ov_a_r  [0:DIV_QW];
  logic              ov_b_r  [0:DIV_QW];
  bsp_side_t         side_r  [0:DIV_QW];

  logic [DIV_DW-1:0] rem_a_nxt [0:DIV_QW];
  logic [DIV_DW-1:0] rem_b_nxt [0:DIV_QW];
  logic [DIV_QW-1:0] sh_a_nxt  [0:DIV_QW];
  logic [DIV_QW-1:0] sh_b_nxt  [0:DIV_QW];

  logic [CMP_W-1:0]  hi_a, hi_b, d_ext;
  logic              ov_a_nxt, ov_b_nxt;

  // entry: overflow check on the upper part, which seeds the remainder
  assign hi_a     = CMP_W'(in_ua[DIV_UW-1:DIV_QW]);
  assign hi_b     = CMP_W'(in_ub[DIV_UW-1:DIV_QW]);
  assign d_ext    = CMP_W'(in_d);
  assign ov_a_nxt = hi_a >= d_ext;
  assign ov_b_nxt = hi_b >= d_ext;
  assign rem_a_nxt[0] = hi_a[DIV_DW-1:0];
  assign rem_b_nxt[0] = hi_b[DIV_DW-1:0];
  assign sh_a_nxt[0]  = in_ua[DIV_QW-1:0];
  assign sh_b_nxt[0]  = in_ub[DIV_QW-1:0];

  // one restoring step per stage for each dividend
  for (genvar k = 1; k <= DIV_QW; k++) begin : g_step
    logic [DIV_DW:0] t_a, t_b, dd;
    logic            ge_a, ge_b;
    assign dd   = {1'b0, d_r[k-1]};
    assign t_a  = {rem_a_r[k-1], sh_a_r[k-1][DIV_QW-1]};
    assign t_b  = {rem_b_r[k-1], sh_b_r[k-1][DIV_QW-1]};
    assign ge_a = t_a >= dd;
    assign ge_b = t_b >= dd;
    assign rem_a_nxt[k] = ge_a ? DIV_DW'(t_a - dd) : t_a[DIV_DW-1:0];
    assign rem_b_nxt[k] = ge_b ? DIV_DW'(t_b - dd) : t_b[DIV_DW-1:0];
    assign sh_a_nxt[k]  = {sh_a_r[k-1][DIV_QW-2:0], ge_a};
    assign sh_b_nxt[k]  = {sh_b_r[k-1][DIV_QW-2:0], ge_b};
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_QW; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int k = 1; k <= DIV_QW; k++) begin
        valid_r[k] <= valid_r[k-1];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]    <= in_d;
      ov_a_r[0] <= ov_a_nxt;
      ov_b_r[0] <= ov_b_nxt;
      side_r[0] <= in_side;
      for (int k = 1; k <= DIV_QW; k++) begin
        d_r[k]    <= d_r[k-1];
        ov_a_r[k] <= ov_a_r[k-1];
        ov_b_r[k] <= ov_b_r[k-1];
        side_r[k] <= side_r[k-1];
      end
      for (int k = 0; k <= DIV_QW; k++) begin
        rem_a_r[k] <= rem_a_nxt[k];
        rem_b_r[k] <= rem_b_nxt[k];
        sh_a_r[k]  <= sh_a_nxt[k];
        sh_b_r[k]  <= sh_b_nxt[k];
      end
    end
  end

  assign out_valid = valid_r[DIV_QW];
  assign out_qa    = sh_a_r[DIV_QW];
  assign out_qb    = sh_b_r[DIV_QW];
  assign out_ova   = ov_a_r[DIV_QW];
  assign out_ovb   = ov_b_r[DIV_QW];
  assign out_side  = side_r[DIV_QW];

endmodule

### src/bsp_back.sv
module bsp_back import bsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [RES_W-1:0]          res_x,
  input  logic [RES_W-1:0]          res_y,
  input  bsp_job_t                  head,
  input  logic                      empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DEPTH_W-1:0] out_depth,
  output logic signed [COL_OUT_W-1:0]  out_screen_col,
  output logic [SIZE_W-1:0]         out_sprite_size,
  output logic [SX_W-1:0]           out_start_x,
  output logic signed [EX_W-1:0]    out_end_x,
  output logic signed [SY_W-1:0]    out_start_y,
  output logic [EY_W-1:0]           out_end_y,
  output logic                      out_div_fault
);

  logic en;

  // divider A: camera transform
  logic [NUM_W-1:0]  mag_x, mag_y;
  logic [DET_W-1:0]  mag_det;
  logic [DIV_UW-1:0] ua_a, ub_a;
  bsp_side_t         side_a_in, side_a_out;
  logic              va_out, ova, ovb;
  logic [DIV_QW-1:0] qa, qb;

  // post stages
  logic                      pa_v_r, ps_v_r, pm_v_r;
  logic                      pa_f_r, ps_f_r, pm_f_r;
  logic signed [DEPTH_W-1:0] pa_tx_r, pa_ty_r, ps_ty_r, pm_ty_r;
  logic signed [DEPTH_W-1:0] tx_nxt, ty_nxt;
  logic signed [SUM_W-1:0]   ps_sum_r;
  logic signed [COLN_W-1:0]  pm_prod_r;
  logic [HALF_W-1:0]         half_x, half_y;

  // divider B: column and size
  logic [COLN_W-1:0] mag_prod;
  logic [DEPTH_W-1:0] mag_ty;
  logic [DIV_UW-1:0] ua_b, ub_b;
  bsp_side_t         side_b_in, side_b_out;
  logic              vb_out, ovc, ovs;
  logic [DIV_QW-1:0] qc, qs;

  // final arithmetic
  logic [16:0]          cap_c, m_c;
  logic signed [COL_OUT_W-1:0] col;
  logic [SIZE_W-1:0]    size;
  logic [SIZE_W-2:0]    hs;
  logic signed [17:0]   sy_w, sx_w, ex_w;
  logic [16:0]          ey_w;
  logic signed [SY_W-1:0] sy;
  logic [EY_W-1:0]      ey;
  logic [SX_W-1:0]      sx;
  logic signed [EX_W-1:0] ex;

  logic                      out_valid_r;
  logic signed [DEPTH_W-1:0] depth_r;
  logic signed [COL_OUT_W-1:0]  col_r;
  logic [SIZE_W-1:0]         size_r;
  logic [SX_W-1:0]           sx_r;
  logic signed [EX_W-1:0]    ex_r;
  logic signed [SY_W-1:0]    sy_r;
  logic [EY_W-1:0]           ey_r;
  logic                      fault_r;

  // whole back pipeline holds while a result waits on a stalled receiver
  assign en  = !out_valid_r || !out_stall;
  assign pop = en && !empty;

  assign half_x = res_x[RES_W-1:1];
  assign half_y = res_y[RES_W-1:1];

  // magnitudes and signs for the transform division
  assign mag_x   = head.num_x[NUM_W-1] ? NUM_W'(-head.num_x) : NUM_W'(head.num_x);
  assign mag_y   = head.num_y[NUM_W-1] ? NUM_W'(-head.num_y) : NUM_W'(head.num_y);
  assign mag_det = head.det[DET_W-1] ? DET_W'(-head.det) : DET_W'(head.det);
  assign ua_a    = DIV_UW'({mag_x, {VEC_FRAC{1'b0}}});
  assign ub_a    = DIV_UW'({mag_y, {VEC_FRAC{1'b0}}});
  assign side_a_in.fault = (head.det == '0);
  assign side_a_in.neg_a = head.num_x[NUM_W-1] ^ head.det[DET_W-1];
  assign side_a_in.neg_b = head.num_y[NUM_W-1] ^ head.det[DET_W-1];
  assign side_a_in.ty    = '0;

  bsp_div2 u_div_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (!empty),
    .in_ua     (ua_a),
    .in_ub     (ub_a),
    .in_d      (mag_det[DIV_DW-1:0]),
    .in_side   (side_a_in),
    .out_valid (va_out),
    .out_qa    (qa),
    .out_qb    (qb),
    .out_ova   (ova),
    .out_ovb   (ovb),
    .out_side  (side_a_out)
  );

  assign tx_nxt = $signed(sat_q(qa, ova, side_a_out.neg_a));
  assign ty_nxt = $signed(sat_q(qb, ovb, side_a_out.neg_b));

  // post stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_v_r <= 1'b0;
      ps_v_r <= 1'b0;
      pm_v_r <= 1'b0;
    end else if (en) begin
      pa_v_r <= va_out;
      ps_v_r <= pa_v_r;
      pm_v_r <= ps_v_r;
    end
  end

  // saturate, sum, scale by half the width
  always_ff @(posedge clk) begin
    if (en) begin
      pa_tx_r   <= tx_nxt;
      pa_ty_r   <= ty_nxt;
      pa_f_r    <= side_a_out.fault || (ty_nxt == '0);
      ps_sum_r  <= SUM_W'(pa_tx_r) + SUM_W'(pa_ty_r);
      ps_ty_r   <= pa_ty_r;
      ps_f_r    <= pa_f_r;
      pm_prod_r <= $signed({1'b0, half_x}) * ps_sum_r;
      pm_ty_r   <= ps_ty_r;
      pm_f_r    <= ps_f_r;
    end
  end

  // operands for column and size division, both over |ty|
  assign mag_prod = pm_prod_r[COLN_W-1] ? COLN_W'(-pm_prod_r) : COLN_W'(pm_prod_r);
  assign mag_ty   = pm_ty_r[DEPTH_W-1] ? DEPTH_W'(-pm_ty_r) : DEPTH_W'(pm_ty_r);
  assign ua_b     = DIV_UW'(mag_prod);
  assign ub_b     = DIV_UW'({res_y, {FRAC_BITS{1'b0}}});
  assign side_b_in.fault = pm_f_r;
  assign side_b_in.neg_a = pm_prod_r[COLN_W-1] ^ pm_ty_r[DEPTH_W-1];
  assign side_b_in.neg_b = 1'b0;
  assign side_b_in.ty    = pm_ty_r;

  bsp_div2 u_div_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pm_v_r),
    .in_ua     (ua_b),
    .in_ub     (ub_b),
    .in_d      (mag_ty[DIV_DW-1:0]),
    .in_side   (side_b_in),
    .out_valid (vb_out),
    .out_qa    (qc),
    .out_qb    (qs),
    .out_ova   (ovc),
    .out_ovb   (ovs),
    .out_side  (side_b_out)
  );

  // column clamped to 16 bits, size to 65535
  assign cap_c = side_b_out.neg_a ? 17'd32768 : 17'd32767;
  assign m_c   = (ovc || (qc > DIV_QW'(cap_c))) ? cap_c : qc[16:0];
  assign col   = side_b_out.neg_a ? COL_OUT_W'(17'd0 - m_c) : COL_OUT_W'(m_c);
  assign size  = (ovs || (qs > DIV_QW'(16'hFFFF))) ? 16'hFFFF : qs[SIZE_W-1:0];
  assign hs    = size[SIZE_W-1:1];

  // draw rectangle with its clamps
  assign sy_w = $signed({6'b0, half_y}) - $signed({3'b0, hs});
  assign sy   = (sy_w < 0) ? -SY_W'(1) : SY_W'(sy_w);
  assign ey_w = 17'(half_y) + 17'(hs);
  assign ey   = (ey_w >= 17'(res_y)) ? EY_W'(res_y - RES_W'(1)) : EY_W'(ey_w);
  assign sx_w = 18'(col) - $signed({3'b0, hs});
  assign sx   = (sx_w < 0) ? '0 : SX_W'(sx_w);
  assign ex_w = 18'(col) + $signed({3'b0, hs});
  assign ex   = (ex_w >= $signed({5'b0, res_x})) ? EX_W'(res_x) : EX_W'(ex_w);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vb_out;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fault_r <= side_b_out.fault;
      if (side_b_out.fault) begin
        depth_r <= '0;
        col_r   <= '0;
        size_r  <= '0;
        sx_r    <= '0;
        ex_r    <= '0;
        sy_r    <= '0;
        ey_r    <= '0;
      end else begin
        depth_r <= $signed(side_b_out.ty);
        col_r   <= col;
        size_r  <= size;
        sx_r    <= sx;
        ex_r    <= ex;
        sy_r    <= sy;
        ey_r    <= ey;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_depth       = depth_r;
  assign out_screen_col  = col_r;
  assign out_sprite_size = size_r;
  assign out_start_x     = sx_r;
  assign out_end_x       = ex_r;
  assign out_start_y     = sy_r;
  assign out_end_y       = ey_r;
  assign out_div_fault   = fault_r;

endmodule

### src/billboard_sprite_projection.sv
// Billboard sprite projection: one sprite cell plus player pose in, one
// camera-space projection with a clamped draw rectangle out.
// Input channel in_*: in_valid with in_stall; a transfer happens when in_valid
// is high and in_stall low. Output channel out_*: out_valid with out_stall.
// Configuration: cfg_we, cfg_index (0 res_x, 1 res_y), cfg_wdata; values are
// clamped to 1..4096 on write; write only while the block holds no item.
// Path from input transfer to out_valid: two
// front stages, the queue, two 33-stage pipelined dividers (one bit per stage,
// transform and then column/size) and four register stages around them.
// Throughput: one item per cycle, dividers included, unless a result is stalled.
// The front fills an 8-entry queue and raises in_stall once queue plus front
// stages hold 8 items. A stalled result freezes the back pipeline only, so
// the front keeps taking items until the queue is full.
// Reset (rst_n low, synchronous) empties the queue and all pipeline valid
// bits and sets res_x to 640 and res_y to 480.
// A zero determinant or zero depth gives div_fault with all other fields 0.
module billboard_sprite_projection import bsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [RES_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [MAP_BITS-1:0]       in_sprite_cell_x,
  input  logic [MAP_BITS-1:0]       in_sprite_cell_y,
  input  logic [POS_W-1:0]          in_player_x,
  input  logic [POS_W-1:0]          in_player_y,
  input  logic signed [VEC_W-1:0]   in_view_dir_x,
  input  logic signed [VEC_W-1:0]   in_view_dir_y,
  input  logic signed [VEC_W-1:0]   in_cam_plane_x,
  input  logic signed [VEC_W-1:0]   in_cam_plane_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DEPTH_W-1:0] out_depth,
  output logic signed [COL_OUT_W-1:0]  out_screen_col,
  output logic [SIZE_W-1:0]         out_sprite_size,
  output logic [SX_W-1:0]           out_start_x,
  output logic signed [EX_W-1:0]    out_end_x,
  output logic signed [SY_W-1:0]    out_start_y,
  output logic [EY_W-1:0]           out_end_y,
  output logic                      out_div_fault
);

  logic [RES_W-1:0] res_x_r, res_y_r;
  logic             push, pop, empty;
  bsp_job_t         job, head;
  logic [Q_CW-1:0]  q_count;

  // resolution registers, stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_x_r <= RES_X_RESET;
      res_y_r <= RES_Y_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RES_X: res_x_r <= clamp_res(cfg_wdata);
        CFG_RES_Y: res_y_r <= clamp_res(cfg_wdata);
      endcase
    end
  end

  bsp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sprite_cell_x (in_sprite_cell_x),
    .in_sprite_cell_y (in_sprite_cell_y),
    .in_player_x      (in_player_x),
    .in_player_y      (in_player_y),
    .in_view_dir_x    (in_view_dir_x),
    .in_view_dir_y    (in_view_dir_y),
    .in_cam_plane_x   (in_cam_plane_x),
    .in_cam_plane_y   (in_cam_plane_y),
    .q_count          (q_count),
    .push             (push),
    .job              (job)
  );

  bsp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .job_in (job),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .count  (q_count)
  );

  bsp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_x           (res_x_r),
    .res_y           (res_y_r),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_depth       (out_depth),
    .out_screen_col  (out_screen_col),
    .out_sprite_size (out_sprite_size),
    .out_start_x     (out_start_x),
    .out_end_x       (out_end_x),
    .out_start_y     (out_start_y),
    .out_end_y       (out_end_y),
    .out_div_fault   (out_div_fault)
  );

endmodule

### src/bsp_chk.sv
module bsp_chk import bsp_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [DEPTH_W-1:0] out_depth,
  input logic signed [COL_OUT_W-1:0]  out_screen_col,
  input logic [SIZE_W-1:0]         out_sprite_size,
  input logic signed [EX_W-1:0]    out_end_x,
  input logic signed [SY_W-1:0]    out_start_y,
  input logic [EY_W-1:0]           out_end_y,
  input logic                      out_div_fault
);

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_depth)
      && $stable(out_screen_col) && $stable(out_end_y))
    else $error("stalled result changed");

  // a fault result carries zeros
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_fault |-> out_depth == 0 && out_sprite_size == 0
      && out_screen_col == 0 && out_end_x == 0)
    else $error("fault result not cleared");

  // zero depth is always flagged
  a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_div_fault |-> out_depth != 0)
    else $error("zero depth without fault");

  // vertical span is never inverted
  a_rows_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_div_fault |-> $signed({out_start_y[SY_W-1], out_start_y})
      <= $signed({2'b00, out_end_y}))
    else $error("start row past end row");

endmodule

bind billboard_sprite_projection bsp_chk u_bsp_chk (.*);

### tb/tb_billboard_sprite_projection.sv
`timescale 1ns / 100ps

module tb_billboard_sprite_projection;
  import bsp_pkg::*;

  typedef struct packed {
    logic [MAP_BITS-1:0]     cx;
    logic [MAP_BITS-1:0]     cy;
    logic [POS_W-1:0]        px;
    logic [POS_W-1:0]        py;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic signed [VEC_W-1:0] plx;
    logic signed [VEC_W-1:0] ply;
  } sprite_req_t;

  typedef struct packed {
    logic signed [DEPTH_W-1:0]   depth;
    logic signed [COL_OUT_W-1:0] col;
    logic [SIZE_W-1:0]           size;
    logic [SX_W-1:0]             sx;
    logic signed [EX_W-1:0]      ex;
    logic signed [SY_W-1:0]      sy;
    logic [EY_W-1:0]             ey;
    logic                        fault;
  } sprite_box_t;

  typedef struct {
    sprite_req_t req;
    bit          typed;
    sprite_box_t box;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RES_X;
  logic [RES_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  sprite_req_t req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sprite_box_t got;

  // projections still owed by the block
  sprite_box_t pending_boxes[$];
  logic [RES_W-1:0] res_x_sh = RES_X_RESET;
  logic [RES_W-1:0] res_y_sh = RES_Y_RESET;
  bit cur_typed = 0;
  sprite_box_t cur_box = '0;
  bit quiet = 0;
  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  int n_fault = 0;
  stim_row_t rows[$];

  billboard_sprite_projection dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sprite_cell_x(req.cx), .in_sprite_cell_y(req.cy),
    .in_player_x(req.px), .in_player_y(req.py),
    .in_view_dir_x(req.dx), .in_view_dir_y(req.dy),
    .in_cam_plane_x(req.plx), .in_cam_plane_y(req.ply),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_depth(got.depth), .out_screen_col(got.col), .out_sprite_size(got.size),
    .out_start_x(got.sx), .out_end_x(got.ex), .out_start_y(got.sy),
    .out_end_y(got.ey), .out_div_fault(got.fault)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  // truncating divide of num*2^sh by den, saturated to signed 32 bits
  function automatic longint trunc_div_sat(longint num, longint den, int sh);
    bit neg;
    longint unsigned un, ud, cap, q1, r, q;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? longint'(-num) : num;
    ud = (den < 0) ? longint'(-den) : den;
    cap = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    q1 = un / ud;
    r = un % ud;
    if (q1 > (cap >> sh)) begin
      q = cap;
    end else begin
      q = (q1 << sh) + ((r << sh) / ud);
      if (q > cap) q = cap;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint res_clamped(logic [RES_W-1:0] v);
    if (v < 1) return 1;
    if (v > 4096) return 4096;
    return longint'(v);
  endfunction

  // camera-space projection and clamped draw rectangle
  function automatic sprite_box_t project_sprite(sprite_req_t s);
    sprite_box_t b;
    longint rx, ry, dx, dy, plx, ply, rsx, rsy, det, tx, ty, col, sz, hs, sy, ey, sx, ex;
    b = '0;
    rx = (longint'(s.cx) <<< FRAC_BITS) + (64'sd1 <<< (FRAC_BITS - 1)) - longint'(s.px);
    ry = (longint'(s.cy) <<< FRAC_BITS) + (64'sd1 <<< (FRAC_BITS - 1)) - longint'(s.py);
    dx = longint'($signed(s.dx));
    dy = longint'($signed(s.dy));
    plx = longint'($signed(s.plx));
    ply = longint'($signed(s.ply));
    rsx = res_clamped(res_x_sh);
    rsy = res_clamped(res_y_sh);
    det = plx * dy - dx * ply;
    if (det == 0) begin
      b.fault = 1'b1;
      return b;
    end
    tx = trunc_div_sat(dy * rx - dx * ry, det, VEC_FRAC);
    ty = trunc_div_sat(plx * ry - ply * rx, det, VEC_FRAC);
    if (ty == 0) begin
      b.fault = 1'b1;
      return b;
    end
    col = trunc_div_sat((rsx >>> 1) * (ty + tx), ty, 0);
    if (col > 32767) col = 32767;
    if (col < -32768) col = -32768;
    sz = trunc_div_sat(rsy, (ty < 0) ? -ty : ty, FRAC_BITS);
    if (sz > 65535) sz = 65535;
    hs = sz >>> 1;
    sy = (rsy >>> 1) - hs;
    if (sy < 0) sy = -1;
    ey = (rsy >>> 1) + hs;
    if (ey >= rsy) ey = rsy - 1;
    sx = col - hs;
    if (sx < 0) sx = 0;
    ex = col + hs;
    if (ex >= rsx) ex = rsx;
    b.depth = DEPTH_W'(ty);
    b.col = COL_OUT_W'(col);
    b.size = SIZE_W'(sz);
    b.sx = SX_W'(sx);
    b.ex = EX_W'(ex);
    b.sy = SY_W'(sy);
    b.ey = EY_W'(ey);
    return b;
  endfunction

  // accepted requests queue their projection, accepted results are checked
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      pending_boxes.push_back(cur_typed ? cur_box : project_sprite(req));
    end
    if (rst_n && out_valid && !out_stall) begin
      n_seen++;
      if (got.fault) n_fault++;
      if (pending_boxes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        if (got !== pending_boxes[0]) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  exp depth %0d col %0d size %0d sx %0d ex %0d sy %0d ey %0d flt %0b",
                     pending_boxes[0].depth, pending_boxes[0].col, pending_boxes[0].size,
                     pending_boxes[0].sx, pending_boxes[0].ex, pending_boxes[0].sy,
                     pending_boxes[0].ey, pending_boxes[0].fault);
            $display("  got depth %0d col %0d size %0d sx %0d ex %0d sy %0d ey %0d flt %0b",
                     got.depth, got.col, got.size, got.sx, got.ex, got.sy, got.ey,
                     got.fault);
          end
        end
        void'(pending_boxes.pop_front());
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 6);
  end

  function automatic sprite_req_t make_req(int cx, int cy, int px, int py,
                                           int dx, int dy, int plx, int ply);
    sprite_req_t s;
    s.cx = MAP_BITS'(cx); s.cy = MAP_BITS'(cy);
    s.px = POS_W'(px); s.py = POS_W'(py);
    s.dx = VEC_W'(dx); s.dy = VEC_W'(dy);
    s.plx = VEC_W'(plx); s.ply = VEC_W'(ply);
    return s;
  endfunction

  // mostly a plausible camera near the sprite, sometimes raw noise
  function automatic sprite_req_t rand_req();
    sprite_req_t s;
    int k, a, b;
    s = ($bits(sprite_req_t))'({$urandom, $urandom, $urandom, $urandom, $urandom});
    k = $urandom_range(9);
    if (k < 7) begin
      s.px = {s.cx + MAP_BITS'($urandom_range(8)) - MAP_BITS'(4), 16'($urandom)};
      s.py = {s.cy + MAP_BITS'($urandom_range(8)) - MAP_BITS'(4), 16'($urandom)};
      a = $urandom_range(32767) - 16384;
      b = $urandom_range(32767) - 16384;
      s.dx = VEC_W'(a); s.dy = VEC_W'(b);
      s.plx = VEC_W'((-b * 2) / 3); s.ply = VEC_W'((a * 2) / 3);
      if (k == 0) begin
        s.plx = s.dx; s.ply = s.dy;
      end
    end else if (k == 7) begin
      s.px = {s.cx, 16'h8000};
      s.py = {s.cy, 16'h8000};
    end
    return s;
  endfunction

  task automatic send(sprite_req_t s, bit typed, sprite_box_t b);
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req = s;
    cur_typed = typed;
    cur_box = b;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    n_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_res(logic [CFG_IDX_W-1:0] idx, logic [RES_W-1:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    if (idx == CFG_RES_X) res_x_sh = v;
    else res_y_sh = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    sprite_box_t fault_box;
    stim_row_t r;
    int rx_list[6];
    int ry_list[6];
    fault_box = '0;
    fault_box.fault = 1'b1;
    rx_list = '{640, 1, 4096, 0, 8191, 320};
    ry_list = '{480, 1, 4096, 8191, 0, 200};

    // directed rows: typed ones are the degenerate cases
    r.typed = 1; r.box = fault_box;
    r.req = make_req(5, 5, 0, 0, 0, 0, 0, 0); rows.push_back(r);
    r.req = make_req(3, 4, 3 * 65536 + 32768, 4 * 65536 + 32768, -16384, 0, 0, 10923);
    rows.push_back(r);
    r.req = make_req(7, 7, 0, 0, 16384, 16384, 16384, 16384); rows.push_back(r);
    r.req = make_req(1023, 1023, 67108863, 67108863, -32768, -32768, -32768, -32768);
    rows.push_back(r);
    r.typed = 0;
    r.req = make_req(10, 5, 5 * 65536, 5 * 65536, -16384, 0, 0, 10923); rows.push_back(r);
    r.req = make_req(5, 10, 5 * 65536, 5 * 65536, 0, 16384, 10923, 0); rows.push_back(r);
    r.req = make_req(0, 0, 67108863, 67108863, 32767, -32768, -32768, 32767);
    rows.push_back(r);
    r.req = make_req(1023, 1023, 0, 0, -32768, 32767, 32767, 32767); rows.push_back(r);
    r.req = make_req(1023, 0, 0, 67108863, 1, 0, 0, 1); rows.push_back(r);
    r.req = make_req(0, 1023, 67108863, 0, -1, 0, 0, -1); rows.push_back(r);
    r.req = make_req(6, 5, 5 * 65536 + 32768, 5 * 65536 + 32768, 16384, 0, 0, -10923);
    rows.push_back(r);
    r.req = make_req(5, 6, 5 * 65536 + 32768, 5 * 65536 + 32767, 0, 16384, 1, 0);
    rows.push_back(r);
    r.req = make_req(500, 500, 499 * 65536, 500 * 65536, 11585, 11585, -7723, 7723);
    rows.push_back(r);
    r.req = make_req(2, 2, 1 * 65536, 2 * 65536 + 32768, -32768, 0, 0, 32767);
    rows.push_back(r);

    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].box);
    drain();

    // one phase per resolution setting, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      write_res(CFG_RES_X, (ph == 5) ? RES_W'($urandom) : RES_W'(rx_list[ph]));
      write_res(CFG_RES_Y, (ph == 5) ? RES_W'($urandom) : RES_W'(ry_list[ph]));
      quiet = (ph == 2);
      for (int i = 0; i < 222; i++) send(rand_req(), 0, '0);
      drain();
    end
    quiet = 0;

    if (pending_boxes.size() != 0) errors++;
    $display("%0d requests sent, %0d projections checked (%0d faults), six resolution settings",
             n_sent, n_seen, n_fault);
    $display("%0d mismatches", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### billboard_sprite_projection.f
src/bsp_pkg.sv
src/bsp_front.sv
src/bsp_queue.sv
src/bsp_div2.sv
src/bsp_back.sv
src/billboard_sprite_projection.sv
src/bsp_chk.sv
tb/tb_billboard_sprite_projection.sv
